// File: rtl/rc4c_pkg.sv
// Shared types and constants for the RC4 chained round stream cipher.
// Used by the controller, the datapath and the top level. No dependencies.
package rc4c_pkg;

  localparam int MAX_ROUNDS_DEF = 16;
  localparam int KEY_BYTES_DEF  = 256;

  localparam int SBOX_DEPTH = 256;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // request kinds carried on s_tuser
  localparam logic [2:0] REQ_LOAD_KEY    = 3'd0;
  localparam logic [2:0] REQ_SCHEDULE    = 3'd1;
  localparam logic [2:0] REQ_RESET_CHAIN = 3'd2;
  localparam logic [2:0] REQ_ENCRYPT     = 3'd3;
  localparam logic [2:0] REQ_DECRYPT     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'd1;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_KEY_WR,
    OP_INIT_CLR,
    OP_INIT_WR,
    OP_KSA1,
    OP_KSA2,
    OP_KSA3,
    OP_KSA4,
    OP_SAVE_RD,
    OP_SAVE_WR,
    OP_REST_RD,
    OP_REST_WR,
    OP_IDX_CLR,
    OP_DRAW1,
    OP_DRAW2,
    OP_DRAW3,
    OP_DRAW4,
    OP_ENC_PRE,
    OP_DEC_PRE,
    OP_BACK_RD,
    OP_BACK_APPLY,
    OP_ENC_POST,
    OP_DEC_POST,
    OP_OUT_LOAD
  } dp_op_t;

  // where a keystream byte goes
  typedef enum logic [1:0] {
    KS_SEED,
    KS_DISCARD,
    KS_XOR,
    KS_ADD
  } ks_dst_t;

  typedef struct packed {
    dp_op_t  op;
    ks_dst_t ks_dst;
    logic    dec;
  } ctl_t;

  typedef struct packed {
    logic k_last;
    logic r_last;
    logic r_zero;
  } sts_t;

endpackage

// File: rtl/rc4_chained_round_stream_cipher_core.sv
// Top level of the RC4 chained round stream cipher: stream ports, config port.
// Depends on rc4c_pkg, rc4c_ctrl, rc4c_datapath (and rc4c_ram below it).
// Encrypt and decrypt time grows with R = effective rounds: each round runs two
// keystream draws, each a read-swap draw (D1..D4) on the single-write-port
// S-box RAM; decrypt adds a backward pass over the stored round bytes.
// One item at a time; rst (synchronous) clears control state, no clearing pass.
module rc4_chained_round_stream_cipher_core #(
  parameter int MAX_ROUNDS = rc4c_pkg::MAX_ROUNDS_DEF,
  parameter int KEY_BYTES  = rc4c_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // data_byte[7:0], key_index[15:8]
  input  logic [2:0]                      s_tuser,   // req_type[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // out_byte[7:0]
  output logic                            m_tuser,   // status[0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc4c_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4c_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rc4c_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rc4c_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_req(s_tuser),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_status(m_tuser),
    .ctl(ctl), .sts(sts)
  );

  rc4c_datapath #(.MAX_ROUNDS(MAX_ROUNDS), .KEY_BYTES(KEY_BYTES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .in_data(s_tdata[7:0]), .in_kidx(s_tdata[15:8]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .out_byte(m_tdata)
  );

endmodule

// File: rtl/rc4c_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rc4c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rc4c_datapath.sv
// Datapath: S-box, saved S-box, key store and round byte RAMs, RC4 indexes,
// chain state and config registers. Depends on rc4c_pkg and rc4c_ram.
module rc4c_datapath #(
  parameter int MAX_ROUNDS = rc4c_pkg::MAX_ROUNDS_DEF,
  parameter int KEY_BYTES  = rc4c_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rc4c_pkg::ctl_t                 ctl,
  output rc4c_pkg::sts_t                 sts,
  input  logic [7:0]                     in_data,
  input  logic [7:0]                     in_kidx,
  input  logic                           cfg_we,
  input  logic [rc4c_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rc4c_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [7:0]                     out_byte
);
  import rc4c_pkg::*;

  localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  // config
  logic [4:0] rounds;
  logic [8:0] key_length;

  // state
  logic [7:0]    idx_i, idx_j, chain_seed, chain_byte;
  logic [7:0]    k, kpos, kmod;
  logic [7:0]    si, sj, t, acc, xr, res, data_q, kidx_q;
  logic [RW-1:0] rc, rl;
  logic [8:0]    len_eff;

  // ram ports
  logic        s_we, v_we, k_we, r_we;
  logic [7:0]  s_wa, s_wd, s_ra, s_rd, v_wa, v_wd, v_ra, v_rd, k_rd, k_ra;
  logic [RW-1:0] r_wa, r_ra;
  logic [15:0] r_wd, r_rd;

  logic [7:0] j_ksa, j_drw, t_drw, ks, p_dec, back;

  rc4c_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_sbox (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  rc4c_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_saved (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );
  rc4c_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_key (
    .clk(clk), .we(k_we), .waddr(kidx_q), .wdata(data_q), .raddr(k_ra), .rdata(k_rd)
  );
  rc4c_ram #(.WIDTH(16), .DEPTH(MAX_ROUNDS)) u_rnd (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
  );

  // clamped config values
  always_comb begin
    if (rounds == 5'd0) begin
      rl = '0;
    end else if ({2'b00, rounds} > 7'(MAX_ROUNDS)) begin
      rl = RW'(MAX_ROUNDS - 1);
    end else begin
      rl = RW'(rounds - 5'd1);
    end
    if (key_length == 9'd0) begin
      len_eff = 9'd1;
    end else if (key_length > 9'(KEY_BYTES)) begin
      len_eff = 9'(KEY_BYTES);
    end else begin
      len_eff = key_length;
    end
  end

  assign sts.k_last = (k == 8'hFF);
  assign sts.r_last = (rc == rl);
  assign sts.r_zero = (rc == '0);

  assign j_ksa = idx_j + s_rd + k_rd;
  assign j_drw = idx_j + s_rd;
  assign t_drw = si + s_rd;
  assign p_dec = acc ^ chain_byte;
  assign back  = (acc - r_rd[7:0]) ^ r_rd[15:8];

  // keystream byte after swap; bypass entries just swapped
  always_comb begin
    if (t == idx_i) begin
      ks = sj;
    end else if (t == idx_j) begin
      ks = si;
    end else begin
      ks = s_rd;
    end
  end

  // RAM port control
  always_comb begin
    s_we = 1'b0; s_wa = k; s_wd = k; s_ra = k;
    v_we = 1'b0; v_wa = k; v_wd = s_rd; v_ra = k;
    k_we = 1'b0; k_ra = kpos;
    r_we = 1'b0; r_wa = rc; r_wd = {xr, ks}; r_ra = rc;
    unique case (ctl.op)
      OP_KEY_WR:  k_we = 1'b1;
      OP_INIT_WR: s_we = 1'b1;
      OP_KSA2:    s_ra = j_ksa;
      OP_KSA3: begin
        s_we = 1'b1; s_wd = s_rd;
      end
      OP_KSA4: begin
        s_we = 1'b1; s_wa = idx_j; s_wd = si;
      end
      OP_SAVE_WR: begin
        v_we = 1'b1; s_ra = k + 8'd1;
      end
      OP_REST_WR: begin
        s_we = 1'b1; s_wd = v_rd; v_ra = k + 8'd1;
      end
      OP_DRAW1:   s_ra = idx_i + 8'd1;
      OP_DRAW2:   s_ra = j_drw;
      OP_DRAW3: begin
        s_we = 1'b1; s_wa = idx_i; s_wd = s_rd; s_ra = t_drw;
      end
      OP_DRAW4: begin
        s_we = 1'b1; s_wa = idx_j; s_wd = si;
        r_we = ctl.dec && (ctl.ks_dst == KS_ADD);
      end
      OP_BACK_APPLY: r_ra = rc - RW'(1);
      default: ;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds     <= 5'd1;
      key_length <= 9'd1;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ROUNDS) begin
        rounds <= cfg_wdata[4:0];
      end else if (cfg_idx == CFG_KEY_LENGTH) begin
        key_length <= cfg_wdata;
      end
    end
  end

  // index and chain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i      <= '0;
      idx_j      <= '0;
      chain_seed <= '0;
      chain_byte <= '0;
      k          <= '0;
      kpos       <= '0;
      kmod       <= '0;
      rc         <= '0;
    end else begin
      unique case (ctl.op)
        OP_INIT_CLR: begin
          k <= '0; kpos <= '0; kmod <= '0; idx_j <= '0;
        end
        OP_INIT_WR, OP_SAVE_WR, OP_REST_WR: k <= k + 8'd1;
        OP_KSA2: idx_j <= j_ksa;
        OP_KSA4: begin
          k <= k + 8'd1;
          if (kmod == 8'(KEY_BYTES - 1)) begin
            kmod <= '0; kpos <= '0;
          end else begin
            kmod <= kmod + 8'd1;
            kpos <= ({1'b0, kpos} + 9'd1 == len_eff) ? 8'd0 : kpos + 8'd1;
          end
        end
        OP_IDX_CLR: begin
          idx_i <= '0; idx_j <= '0;
        end
        OP_DRAW1: idx_i <= idx_i + 8'd1;
        OP_DRAW2: idx_j <= j_drw;
        OP_DRAW4: begin
          unique case (ctl.ks_dst)
            KS_SEED: begin
              chain_seed <= ks; chain_byte <= ks;
            end
            KS_DISCARD: chain_byte <= chain_seed;
            KS_XOR: ;
            KS_ADD: if (rc != rl) rc <= rc + RW'(1);
          endcase
        end
        OP_ENC_PRE: begin
          chain_byte <= chain_byte ^ data_q; rc <= '0;
        end
        OP_DEC_PRE: rc <= '0;
        OP_BACK_APPLY: if (rc != '0) rc <= rc - RW'(1);
        OP_DEC_POST: chain_byte <= chain_byte ^ p_dec;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LATCH: begin
        data_q <= in_data; kidx_q <= in_kidx; res <= '0;
      end
      OP_KSA2, OP_DRAW2: si <= s_rd;
      OP_DRAW3: begin
        sj <= s_rd; t <= t_drw;
      end
      OP_DRAW4: begin
        if (ctl.ks_dst == KS_XOR) begin
          if (ctl.dec) xr <= ks;
          else         acc <= acc ^ ks;
        end else if (ctl.ks_dst == KS_ADD && !ctl.dec) begin
          acc <= acc + ks;
        end
      end
      OP_ENC_PRE:    acc <= chain_byte ^ data_q;
      OP_DEC_PRE:    acc <= data_q;
      OP_BACK_APPLY: acc <= back;
      OP_ENC_POST:   res <= acc;
      OP_DEC_POST:   res <= p_dec;
      OP_OUT_LOAD:   out_byte <= res;
      default: ;
    endcase
  end

endmodule

// File: rtl/rc4c_ctrl.sv
// Controller: sequences key load, key schedule, chain reset and the round
// draws of encrypt/decrypt. Depends on rc4c_pkg.
module rc4c_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_status,
  output rc4c_pkg::ctl_t ctl,
  input  rc4c_pkg::sts_t sts
);
  import rc4c_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LATCH, ST_KEY, ST_CLR, ST_INIT, ST_KSA1, ST_KSA2, ST_KSA3, ST_KSA4,
    ST_SVRD, ST_SVWR, ST_RSCLR, ST_RSRD, ST_RSWR, ST_IDX,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_ENCP, ST_DECP, ST_BKRD, ST_BKAP,
    ST_ENCPOST, ST_DECPOST, ST_DONE
  } state_t;

  state_t     state;
  logic [2:0] req_q;
  ks_dst_t    ksd;
  logic       keyed, stat_pend;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  // command decode; payload is captured on the accepting edge
  always_comb begin
    ctl.ks_dst = ksd;
    ctl.dec    = (req_q == REQ_DECRYPT);
    unique case (state)
      ST_IDLE:    ctl.op = in_valid ? OP_LATCH : OP_NONE;
      ST_LATCH:   ctl.op = OP_NONE;
      ST_KEY:     ctl.op = OP_KEY_WR;
      ST_CLR:     ctl.op = OP_INIT_CLR;
      ST_INIT:    ctl.op = OP_INIT_WR;
      ST_KSA1:    ctl.op = OP_KSA1;
      ST_KSA2:    ctl.op = OP_KSA2;
      ST_KSA3:    ctl.op = OP_KSA3;
      ST_KSA4:    ctl.op = OP_KSA4;
      ST_SVRD:    ctl.op = OP_SAVE_RD;
      ST_SVWR:    ctl.op = OP_SAVE_WR;
      ST_RSCLR:   ctl.op = OP_INIT_CLR;
      ST_RSRD:    ctl.op = OP_REST_RD;
      ST_RSWR:    ctl.op = OP_REST_WR;
      ST_IDX:     ctl.op = OP_IDX_CLR;
      ST_D1:      ctl.op = OP_DRAW1;
      ST_D2:      ctl.op = OP_DRAW2;
      ST_D3:      ctl.op = OP_DRAW3;
      ST_D4:      ctl.op = OP_DRAW4;
      ST_ENCP:    ctl.op = OP_ENC_PRE;
      ST_DECP:    ctl.op = OP_DEC_PRE;
      ST_BKRD:    ctl.op = OP_BACK_RD;
      ST_BKAP:    ctl.op = OP_BACK_APPLY;
      ST_ENCPOST: ctl.op = OP_ENC_POST;
      ST_DECPOST: ctl.op = OP_DEC_POST;
      ST_DONE:    ctl.op = slot_free ? OP_OUT_LOAD : OP_NONE;
      default:    ctl.op = OP_NONE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      req_q      <= REQ_LOAD_KEY;
      ksd        <= KS_SEED;
      keyed      <= 1'b0;
      stat_pend  <= 1'b0;
      out_valid  <= 1'b0;
      out_status <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_q     <= in_req;
            stat_pend <= 1'b0;
            state     <= ST_LATCH;
          end
        end
        ST_LATCH: begin
          priority case (req_q)
            REQ_LOAD_KEY: state <= ST_KEY;
            REQ_SCHEDULE: state <= ST_CLR;
            REQ_RESET_CHAIN, REQ_ENCRYPT, REQ_DECRYPT: begin
              if (!keyed) begin
                stat_pend <= 1'b1;
                state     <= ST_DONE;
              end else if (req_q == REQ_RESET_CHAIN) begin
                state <= ST_RSCLR;
              end else if (req_q == REQ_ENCRYPT) begin
                state <= ST_ENCP;
              end else begin
                state <= ST_DECP;
              end
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_KEY:  state <= ST_DONE;
        ST_CLR:  state <= ST_INIT;
        ST_INIT: if (sts.k_last) state <= ST_KSA1;
        ST_KSA1: state <= ST_KSA2;
        ST_KSA2: state <= ST_KSA3;
        ST_KSA3: state <= ST_KSA4;
        ST_KSA4: state <= sts.k_last ? ST_SVRD : ST_KSA1;
        ST_SVRD: state <= ST_SVWR;
        ST_SVWR: begin
          if (sts.k_last) begin
            ksd   <= KS_SEED;
            state <= ST_IDX;
          end
        end
        ST_RSCLR: state <= ST_RSRD;
        ST_RSRD:  state <= ST_RSWR;
        ST_RSWR: begin
          if (sts.k_last) begin
            ksd   <= KS_DISCARD;
            state <= ST_IDX;
          end
        end
        ST_IDX: state <= ST_D1;
        ST_D1:  state <= ST_D2;
        ST_D2:  state <= ST_D3;
        ST_D3:  state <= ST_D4;
        ST_D4: begin
          unique case (ksd)
            KS_SEED: begin
              keyed <= 1'b1;
              state <= ST_DONE;
            end
            KS_DISCARD: state <= ST_DONE;
            KS_XOR: begin
              ksd   <= KS_ADD;
              state <= ST_D1;
            end
            KS_ADD: begin
              if (sts.r_last) begin
                state <= (req_q == REQ_DECRYPT) ? ST_BKRD : ST_ENCPOST;
              end else begin
                ksd   <= KS_XOR;
                state <= ST_D1;
              end
            end
          endcase
        end
        ST_ENCP, ST_DECP: begin
          ksd   <= KS_XOR;
          state <= ST_D1;
        end
        ST_BKRD:    state <= ST_BKAP;
        ST_BKAP:    if (sts.r_zero) state <= ST_DECPOST;
        ST_ENCPOST: state <= ST_DONE;
        ST_DECPOST: state <= ST_DONE;
        ST_DONE: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= stat_pend;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result is posted as soon as the output slot frees up
  a_done_posts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && slot_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not posted from done state");

  // once keyed, the cipher stays keyed
  a_keyed_holds: assert property (@(posedge clk) disable iff (rst) !$fell(keyed))
    else $error("keyed flag dropped");

  // not-keyed status only for chain/encrypt/decrypt requests
  a_status_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && stat_pend) |->
      (req_q == REQ_RESET_CHAIN || req_q == REQ_ENCRYPT || req_q == REQ_DECRYPT))
    else $error("not-keyed status on wrong request");

  // schedule ends its swap pass after the last S-box entry
  a_ksa_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KSA4 && sts.k_last) |=> (state == ST_SVRD))
    else $error("key schedule did not leave swap pass");

endmodule
